>>> rtl/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

    // Fixed field widths
    localparam int CODE_W     = 64;
    localparam int LEN_W      = 5;
    localparam int DEB_W      = 8;
    localparam int KEY_W      = 4;
    localparam int DIGITS_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int DEFAULT_MAX_DIGITS = 16;

    // Register reset values
    localparam logic [CODE_W-1:0] USER_CODE_RST  = 64'h0000_0000_0000_9999;
    localparam logic [LEN_W-1:0]  USER_LEN_RST   = 5'd4;
    localparam logic [CODE_W-1:0] ADMIN_CODE_RST = 64'h0000_0000_0000_0963;
    localparam logic [LEN_W-1:0]  ADMIN_LEN_RST  = 5'd3;
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 8'd180;

    localparam logic [DEB_W-1:0]  SINCE_MAX      = 8'd255;

    // Event kinds
    localparam logic EV_PRESS = 1'b0;
    localparam logic EV_TICK  = 1'b1;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX  = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR       = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH       = 4'd11;
    localparam logic [KEY_W-1:0] KEY_ADMIN_EXIT = 4'd0;
    localparam logic [KEY_W-1:0] KEY_ADMIN_ADD  = 4'd1;
    localparam logic [KEY_W-1:0] KEY_ADMIN_DEL  = 4'd2;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ENTER = 2'd1,
        MODE_ADMIN = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USER_CODE  = 3'd0,
        CFG_USER_LEN   = 3'd1,
        CFG_ADMIN_CODE = 3'd2,
        CFG_ADMIN_LEN  = 3'd3,
        CFG_DEBOUNCE   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CODE_W-1:0] user_code;
        logic [LEN_W-1:0]  user_len;
        logic [CODE_W-1:0] admin_code;
        logic [LEN_W-1:0]  admin_len;
        logic [DEB_W-1:0]  debounce;
    } t_cfg;

    typedef struct packed {
        logic                key_accepted;
        t_mode               mode;
        logic [DIGITS_W-1:0] digits_entered;
        logic                unlock;
        logic                wrong_code;
        logic                admin_entered;
        logic                enrol_request;
        logic                remove_request;
    } t_result;

endpackage

>>> rtl/kcl_step.sv
`timescale 1ns / 1ps

// Lock state plus the single-pass next-state/result logic for one request.
module kcl_step import kcl_pkg::*; #(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_event_kind,
    input  logic [KEY_W-1:0] i_key_code,
    input  t_cfg             i_cfg,
    output t_result          o_result
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    t_mode              r_mode, n_mode;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [DEB_W-1:0]   r_since, n_since;
    logic [KEY_W-1:0]   r_store [MAX_DIGITS];

    logic               w_press_ok;
    logic               w_is_digit;
    logic               w_has_room;
    logic               w_append;
    logic [CNT_W-1:0]   w_count_app;
    logic [LEN_W-1:0]   w_ulen, w_alen;
    logic [KEY_W-1:0]   w_app [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] w_user_ok, w_admin_ok;
    logic               w_user_match, w_admin_match, w_len_reached;

    assign w_press_ok = (i_event_kind == EV_PRESS) && (r_since >= i_cfg.debounce);
    assign w_is_digit = (i_key_code <= KEY_DIGIT_MAX);
    assign w_has_room = (r_count < CNT_W'(MAX_DIGITS));
    assign w_append   = w_press_ok && (r_mode == MODE_ENTER) && w_is_digit;
    assign w_count_app = w_has_room ? r_count + 1'b1 : r_count;

    // Lengths above the store depth act as the store depth
    assign w_ulen = (i_cfg.user_len > LEN_W'(MAX_DIGITS))
                    ? LEN_W'(MAX_DIGITS) : i_cfg.user_len;
    assign w_alen = (i_cfg.admin_len > LEN_W'(MAX_DIGITS))
                    ? LEN_W'(MAX_DIGITS) : i_cfg.admin_len;

    // One compare lane per digit slot, on the entry with the new digit in place
    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_lane
        assign w_app[g] = (w_has_room && r_count == CNT_W'(g)) ? i_key_code : r_store[g];
        assign w_user_ok[g]  = (LEN_W'(g) >= w_ulen) ||
                               (w_app[g] == i_cfg.user_code[KEY_W*g +: KEY_W]);
        assign w_admin_ok[g] = (LEN_W'(g) >= w_alen) ||
                               (w_app[g] == i_cfg.admin_code[KEY_W*g +: KEY_W]);
    end

    assign w_user_match  = (w_ulen != '0) && (LEN_W'(w_count_app) == w_ulen) && (&w_user_ok);
    assign w_admin_match = (w_alen != '0) && (LEN_W'(w_count_app) == w_alen) && (&w_admin_ok);
    assign w_len_reached = (LEN_W'(w_count_app) >= w_ulen);

    // Next mode
    always_comb begin
        n_mode = r_mode;
        if (w_press_ok) begin
            case (r_mode)
                MODE_IDLE: begin
                    if (i_key_code == KEY_HASH) n_mode = MODE_ENTER;
                end
                MODE_ENTER: begin
                    if (i_key_code == KEY_STAR) begin
                        n_mode = MODE_IDLE;
                    end else if (w_is_digit) begin
                        if (w_user_match)       n_mode = MODE_IDLE;
                        else if (w_admin_match) n_mode = MODE_ADMIN;
                        else if (w_len_reached) n_mode = MODE_IDLE;
                    end
                end
                MODE_ADMIN: begin
                    if (i_key_code == KEY_ADMIN_EXIT || i_key_code == KEY_ADMIN_ADD ||
                        i_key_code == KEY_ADMIN_DEL) begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: n_mode = MODE_IDLE;
            endcase
        end
    end

    // Digit count and debounce counter
    always_comb begin
        n_count = r_count;
        n_since = r_since;
        if (i_event_kind == EV_TICK) begin
            if (r_since != SINCE_MAX) n_since = r_since + 1'b1;
        end else if (w_press_ok) begin
            n_since = '0;
            case (r_mode)
                MODE_IDLE: begin
                    if (i_key_code == KEY_HASH) n_count = '0;
                end
                MODE_ENTER: begin
                    if (i_key_code == KEY_STAR) begin
                        n_count = '0;
                    end else if (w_is_digit) begin
                        if (w_user_match || w_admin_match || w_len_reached) n_count = '0;
                        else                                                 n_count = w_count_app;
                    end
                end
                default: n_count = r_count;
            endcase
        end
    end

    // Result of this request
    always_comb begin
        o_result                = '0;
        o_result.key_accepted   = w_press_ok;
        o_result.mode           = n_mode;
        o_result.digits_entered = DIGITS_W'(n_count);
        o_result.unlock         = w_append && w_user_match;
        o_result.admin_entered  = w_append && !w_user_match && w_admin_match;
        o_result.wrong_code     = w_append && !w_user_match && !w_admin_match && w_len_reached;
        o_result.enrol_request  = w_press_ok && (r_mode == MODE_ADMIN) &&
                                  (i_key_code == KEY_ADMIN_ADD);
        o_result.remove_request = w_press_ok && (r_mode == MODE_ADMIN) &&
                                  (i_key_code == KEY_ADMIN_DEL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
            r_since <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_since <= n_since;
        end
    end

    // Digit slots: no reset, only slots below the count are ever compared
    always_ff @(posedge i_clk) begin
        if (i_step && w_append && w_has_room) begin
            r_store[r_count[IDX_W-1:0]] <= i_key_code;
        end
    end

endmodule

>>> rtl/keypad_code_lock_controller.sv
`timescale 1ns / 1ps

// Channel    | Dir | Handshake               | Payload
// -----------+-----+-------------------------+-------------------------------------------
// input      | in  | i_in_valid / o_in_stall | i_event_kind, i_key_code
// result     | out | o_out_valid/i_out_stall | o_key_accepted, o_mode, o_digits_entered,
//            |     |                         | o_unlock, o_wrong_code, o_admin_entered,
//            |     |                         | o_enrol_request, o_remove_request
// config     | in  | i_cfg_wr_en             | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while i_out_stall is low. A request is held in the
// input register, then the lock logic evaluates it in a single pass into the
// result register, which drives the result port.
// Synchronous active-low reset loads the register defaults, sets mode idle,
// zero digits and a zero debounce count; the digit slots are not cleared.
// o_in_stall is high during reset and while the input register is full and
// the result register is held by i_out_stall.
module keypad_code_lock_controller import kcl_pkg::*; #(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_event_kind,
    input  logic [KEY_W-1:0]      i_key_code,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_key_accepted,
    output logic [1:0]            o_mode,
    output logic [DIGITS_W-1:0]   o_digits_entered,
    output logic                  o_unlock,
    output logic                  o_wrong_code,
    output logic                  o_admin_entered,
    output logic                  o_enrol_request,
    output logic                  o_remove_request,
    // configuration writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic             r_in_kind;
    logic [KEY_W-1:0] r_in_key;
    logic             r_out_valid;
    t_result          r_out;
    t_result          w_result;
    logic             w_advance;
    logic             w_accept;

    // Move the held request into the result register when that slot is free
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_in_valid && !w_advance);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.user_code  <= USER_CODE_RST;
            r_cfg.user_len   <= USER_LEN_RST;
            r_cfg.admin_code <= ADMIN_CODE_RST;
            r_cfg.admin_len  <= ADMIN_LEN_RST;
            r_cfg.debounce   <= DEBOUNCE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_USER_CODE:  r_cfg.user_code  <= i_cfg_data;
                CFG_USER_LEN:   r_cfg.user_len   <= i_cfg_data[LEN_W-1:0];
                CFG_ADMIN_CODE: r_cfg.admin_code <= i_cfg_data;
                CFG_ADMIN_LEN:  r_cfg.admin_len  <= i_cfg_data[LEN_W-1:0];
                CFG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind <= i_event_kind;
            r_in_key  <= i_key_code;
        end
    end

    kcl_step #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_event_kind (r_in_kind),
        .i_key_code   (r_in_key),
        .i_cfg        (r_cfg),
        .o_result     (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_key_accepted   = r_out.key_accepted;
    assign o_mode           = r_out.mode;
    assign o_digits_entered = r_out.digits_entered;
    assign o_unlock         = r_out.unlock;
    assign o_wrong_code     = r_out.wrong_code;
    assign o_admin_entered  = r_out.admin_entered;
    assign o_enrol_request  = r_out.enrol_request;
    assign o_remove_request = r_out.remove_request;

endmodule

>>> rtl/kcl_checker.sv
`timescale 1ns / 1ps

module kcl_checker import kcl_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_key_accepted,
    input logic [1:0]          i_mode,
    input logic [DIGITS_W-1:0] i_digits_entered,
    input logic                i_unlock,
    input logic                i_wrong_code,
    input logic                i_admin_entered,
    input logic                i_enrol_request,
    input logic                i_remove_request
);

    // At most one event per result
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0({i_unlock, i_wrong_code, i_admin_entered,
                                  i_enrol_request, i_remove_request}))
        else $error("more than one event pulse in a result");

    // Events only come from a press that got through debounce
    a_pulse_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_unlock || i_wrong_code || i_admin_entered ||
                         i_enrol_request || i_remove_request)) |-> i_key_accepted)
        else $error("event pulse without an accepted key");

    // Finished entry returns to idle with an empty entry
    a_entry_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_unlock || i_wrong_code || i_enrol_request || i_remove_request))
        |-> (i_mode == MODE_IDLE && i_digits_entered == '0))
        else $error("entry end did not return to idle with no digits");

    a_admin_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_admin_entered) |-> (i_mode == MODE_ADMIN && i_digits_entered == '0))
        else $error("admin match did not enter admin mode");

endmodule

bind keypad_code_lock_controller kcl_checker u_kcl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_valid),
    .i_key_accepted   (o_key_accepted),
    .i_mode           (o_mode),
    .i_digits_entered (o_digits_entered),
    .i_unlock         (o_unlock),
    .i_wrong_code     (o_wrong_code),
    .i_admin_entered  (o_admin_entered),
    .i_enrol_request  (o_enrol_request),
    .i_remove_request (o_remove_request)
);
